@@ rtl/lprd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprd_pkg: shared types and constants of the record deframer
// Phase codes, result kinds, status codes, the result word layout and the
// four-byte magic that opens every record.
// ----------------------------------------------------------------------------
package lprd_pkg;

	typedef enum logic [2:0] {
		PH_MAGIC         = 3'd0,
		PH_LEN           = 3'd1,
		PH_PAYLOAD       = 3'd2,
		PH_COUNT         = 3'd3,
		PH_CLAIM_LEN     = 3'd4,
		PH_CLAIM_PAYLOAD = 3'd5,
		PH_DONE          = 3'd6,
		PH_ERROR         = 3'd7
	} phase_t;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	localparam logic [2:0] TAG_NONCE = 3'd0;
	localparam logic [2:0] TAG_CLAIM = 3'd4;

	// Result queue depth; two free entries are needed to take a word.
	localparam int RQ_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  tag;
		logic [31:0] claim;
		logic [7:0]  pbyte;
		logic        fend;
		logic [1:0]  status;
		logic        fin;
	} result_t;

	// Results that one accepted word pushes into the queue, in order.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h4C;
			2'd1:    b = 8'h4B;
			2'd2:    b = 8'h50;
			default: b = 8'h32;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

@@ rtl/length_prefixed_record_deframer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer_unit: byte-wide record deframer
// Checks the magic, walks four length-prefixed fields and a counted list of
// length-prefixed claims, and emits tagged payload bytes, empty markers and a
// final status per blob.
//
//   channel   handshake                  payload
//   input     data_valid / data_ready    data_byte, last
//   result    result_valid / result_ready result_kind .. is_final
//
// One word is taken per cycle while data_ready is high; its results are
// registered in a four-entry result queue and appear on the result channel
// from the next cycle on. A word with last set yields up to two results, so
// the result channel (one result per cycle while result_ready is high) sets
// the sustained rate when many blobs are short. data_ready is high while the
// queue has two free entries; it depends only on registered state. Reset
// returns the parser to the magic check and empties the queue.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       result_kind,
	output logic [2:0]       field_tag,
	output logic [31:0]      claim_number,
	output logic [7:0]       payload_byte,
	output logic             field_end,
	output logic [1:0]       status,
	output logic             is_final
);

	lprd_pkg::push_t   push;
	lprd_pkg::result_t rdata;
	logic              acc;

	assign acc = data_valid && data_ready;

	lprd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.data_byte (data_byte),
		.last      (last),
		.push      (push)
	);

	lprd_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (data_ready),
		.rvalid (result_valid),
		.rready (result_ready),
		.rdata  (rdata)
	);

	assign result_kind  = rdata.kind;
	assign field_tag    = rdata.tag;
	assign claim_number = rdata.claim;
	assign payload_byte = rdata.pbyte;
	assign field_end    = rdata.fend;
	assign status       = rdata.status;
	assign is_final     = rdata.fin;

endmodule
`default_nettype wire

@@ rtl/lprd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprd_parser: record parsing state and per-word result generation
// Holds the parse state and, for the word being accepted, works out the next
// state and the payload, marker and status results it causes.
// ----------------------------------------------------------------------------
module lprd_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           acc,
	input  wire logic [7:0]     data_byte,
	input  wire logic           last,
	output lprd_pkg::push_t     push
);

	lprd_pkg::phase_t phase_q, phase_d;
	logic [1:0]  pcnt_q, pcnt_d;
	logic [23:0] lacc_q, lacc_d;
	logic [31:0] brem_q, brem_d;
	logic [2:0]  cfield_q, cfield_d;
	logic [31:0] ctotal_q, ctotal_d;
	logic [31:0] ccnt_q, ccnt_d;

	logic [31:0] acc_word;
	logic [31:0] rem;
	logic [31:0] ccnt_inc;
	logic [2:0]  cfield_inc;
	logic [31:0] claim_cur;
	logic        item_end;
	logic        prim_v;
	lprd_pkg::result_t prim;
	lprd_pkg::result_t stat;

	assign acc_word   = {lacc_q, data_byte};
	assign rem        = brem_q - 32'd1;
	assign ccnt_inc   = ccnt_q + 32'd1;
	assign cfield_inc = cfield_q + 3'd1;
	assign claim_cur  = (cfield_q == lprd_pkg::TAG_CLAIM) ? ccnt_q : 32'd0;
	assign item_end   = prim_v && prim.fend;

	// Payload byte or empty marker produced by the word at the input.
	always_comb begin
		prim_v = 1'b0;
		prim   = '0;
		unique case (phase_q) inside
			lprd_pkg::PH_LEN, lprd_pkg::PH_CLAIM_LEN: begin
				if (pcnt_q == 2'd3 && acc_word == 32'd0) begin
					prim_v     = 1'b1;
					prim.kind  = lprd_pkg::KIND_EMPTY;
					prim.tag   = cfield_q;
					prim.claim = claim_cur;
					prim.fend  = 1'b1;
				end
			end
			lprd_pkg::PH_PAYLOAD, lprd_pkg::PH_CLAIM_PAYLOAD: begin
				prim_v     = 1'b1;
				prim.kind  = lprd_pkg::KIND_PAYLOAD;
				prim.tag   = cfield_q;
				prim.claim = claim_cur;
				prim.pbyte = data_byte;
				prim.fend  = (rem == 32'd0);
			end
			default: begin
				// No payload or marker in the other phases.
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		pcnt_d   = pcnt_q;
		lacc_d   = lacc_q;
		brem_d   = brem_q;
		cfield_d = cfield_q;
		ctotal_d = ctotal_q;
		ccnt_d   = ccnt_q;

		unique case (phase_q) inside
			lprd_pkg::PH_MAGIC: begin
				if (data_byte != lprd_pkg::magic_byte(pcnt_q)) begin
					phase_d = lprd_pkg::PH_ERROR;
				end else if (pcnt_q == 2'd3) begin
					pcnt_d   = 2'd0;
					lacc_d   = '0;
					cfield_d = lprd_pkg::TAG_NONCE;
					phase_d  = lprd_pkg::PH_LEN;
				end else begin
					pcnt_d = pcnt_q + 2'd1;
				end
			end
			lprd_pkg::PH_LEN, lprd_pkg::PH_CLAIM_LEN, lprd_pkg::PH_COUNT: begin
				if (pcnt_q != 2'd3) begin
					lacc_d = acc_word[23:0];
					pcnt_d = pcnt_q + 2'd1;
				end else begin
					pcnt_d = 2'd0;
					lacc_d = '0;
					if (phase_q == lprd_pkg::PH_COUNT) begin
						ctotal_d = acc_word;
						ccnt_d   = '0;
						phase_d  = (acc_word == 32'd0) ? lprd_pkg::PH_DONE
						                                : lprd_pkg::PH_CLAIM_LEN;
					end else if (acc_word != 32'd0) begin
						brem_d  = acc_word;
						phase_d = (phase_q == lprd_pkg::PH_LEN) ? lprd_pkg::PH_PAYLOAD
						                                         : lprd_pkg::PH_CLAIM_PAYLOAD;
					end
				end
			end
			lprd_pkg::PH_PAYLOAD, lprd_pkg::PH_CLAIM_PAYLOAD: begin
				brem_d = rem;
			end
			default: begin
				// Record complete or in error: the word is dropped.
			end
		endcase

		// A field or claim has ended: move on to the next one.
		if (item_end) begin
			pcnt_d = 2'd0;
			lacc_d = '0;
			if (phase_q == lprd_pkg::PH_LEN || phase_q == lprd_pkg::PH_PAYLOAD) begin
				if (cfield_inc >= 3'd4) begin
					cfield_d = lprd_pkg::TAG_CLAIM;
					phase_d  = lprd_pkg::PH_COUNT;
				end else begin
					cfield_d = cfield_inc;
					phase_d  = lprd_pkg::PH_LEN;
				end
			end else begin
				ccnt_d  = ccnt_inc;
				phase_d = (ccnt_inc == ctotal_q) ? lprd_pkg::PH_DONE
				                                 : lprd_pkg::PH_CLAIM_LEN;
			end
		end
	end

	always_comb begin
		stat      = '0;
		stat.kind = lprd_pkg::KIND_STATUS;
		stat.fin  = 1'b1;
		unique case (phase_d) inside
			lprd_pkg::PH_DONE:                      stat.status = lprd_pkg::ST_OK;
			lprd_pkg::PH_ERROR, lprd_pkg::PH_MAGIC: stat.status = lprd_pkg::ST_BAD_MAGIC;
			default:                                stat.status = lprd_pkg::ST_TRUNCATED;
		endcase
	end

	always_comb begin
		push.first  = prim_v ? prim : stat;
		push.second = stat;
		if (!acc) begin
			push.cnt = 2'd0;
		end else begin
			push.cnt = {1'b0, prim_v} + {1'b0, last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lprd_pkg::PH_MAGIC;
			pcnt_q   <= '0;
			lacc_q   <= '0;
			brem_q   <= '0;
			cfield_q <= '0;
			ctotal_q <= '0;
			ccnt_q   <= '0;
		end else if (acc) begin
			if (last) begin
				// The blob closes: start over for the next one.
				phase_q  <= lprd_pkg::PH_MAGIC;
				pcnt_q   <= '0;
				lacc_q   <= '0;
				brem_q   <= '0;
				cfield_q <= '0;
				ctotal_q <= '0;
				ccnt_q   <= '0;
			end else begin
				phase_q  <= phase_d;
				pcnt_q   <= pcnt_d;
				lacc_q   <= lacc_d;
				brem_q   <= brem_d;
				cfield_q <= cfield_d;
				ctotal_q <= ctotal_d;
				ccnt_q   <= ccnt_d;
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last) |=> (phase_q == lprd_pkg::PH_MAGIC))
		else $error("parser did not restart after the last word");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lprd_pkg::PH_PAYLOAD || phase_q == lprd_pkg::PH_CLAIM_PAYLOAD)
		|-> (brem_q != 32'd0))
		else $error("payload phase with nothing remaining");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cfield_q <= lprd_pkg::TAG_CLAIM))
		else $error("field tag out of range");

endmodule
`default_nettype wire

@@ rtl/lprd_result_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprd_result_queue: small queue of finished results
// Takes up to two results per cycle from the parser and hands them out one
// per cycle on the result channel while rready is high.
// ----------------------------------------------------------------------------
module lprd_result_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lprd_pkg::push_t   push,
	output logic                   room,
	output logic                   rvalid,
	input  wire logic              rready,
	output lprd_pkg::result_t      rdata
);

	localparam int PW = $clog2(lprd_pkg::RQ_DEPTH);
	localparam int CW = $clog2(lprd_pkg::RQ_DEPTH + 1);

	lprd_pkg::result_t ent_q [lprd_pkg::RQ_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wp_nx1;
	logic          pop;

	assign pop    = rvalid && rready;
	assign rvalid = (count_q != '0);
	assign rdata  = ent_q[rp_q];
	assign room   = (count_q <= CW'(lprd_pkg::RQ_DEPTH - 2));
	assign wp_nx1 = wp_q + PW'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			ent_q[wp_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			ent_q[wp_nx1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(push.cnt);
			rp_q    <= rp_q + PW'(pop);
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (count_q <= CW'(lprd_pkg::RQ_DEPTH - 2)))
		else $error("result queue pushed without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.cnt == 2'd0) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("result queue count did not fall on a pop");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(lprd_pkg::RQ_DEPTH)))
		else $error("result queue count beyond depth");

endmodule
`default_nettype wire
